FILE: hdl/voxel_face_culling_core_macros.svh
// ---------------------------------------------------------------------------
// Voxel face culling core - assertion macros
// Shared assertion forms for the face culling core; clk and rst_n are
// taken from the scope that uses them.
// ---------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLING_CORE_MACROS_SVH
`define VOXEL_FACE_CULLING_CORE_MACROS_SVH

// Same-cycle implication.
`define VFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/vfc_pkg.sv
// ---------------------------------------------------------------------------
// Voxel face culling package
// Field types, probe codes and the face count helper.
// ---------------------------------------------------------------------------
package vfc_pkg;

    typedef logic [3:0] coord_t;       // voxel coordinate as carried on the bus
    typedef logic [6:0] coord_ext_t;   // coordinate with room for +1 / wrap of -1
    typedef logic [5:0] face_mask_t;
    typedef logic [2:0] face_count_t;
    typedef logic [2:0] probe_sel_t;

    localparam int FACE_TOTAL  = 6;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;

    // command codes (tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // probe order; face probes map to mask bits 0..5 in this order
    localparam probe_sel_t PROBE_SELF = 3'd0;
    localparam probe_sel_t PROBE_Y_DN = 3'd1;
    localparam probe_sel_t PROBE_Y_UP = 3'd2;
    localparam probe_sel_t PROBE_Z_DN = 3'd3;
    localparam probe_sel_t PROBE_Z_UP = 3'd4;
    localparam probe_sel_t PROBE_X_UP = 3'd5;
    localparam probe_sel_t PROBE_X_DN = 3'd6;

    function automatic face_count_t face_popcount(input face_mask_t mask);
        face_count_t cnt;
        cnt = '0;
        for (int i = 0; i < FACE_TOTAL; i++)
        begin
            cnt = cnt + face_count_t'(mask[i]);
        end
        return cnt;
    endfunction

endpackage

FILE: hdl/vfc_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ---------------------------------------------------------------------------
module vfc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/vfc_probe.sv
// ---------------------------------------------------------------------------
// Voxel face culling - probe address generator
// Offsets the base voxel toward the selected face, checks the chunk bounds
// and forms the linear occupancy address (x * E + y) * E + z.
// ---------------------------------------------------------------------------
module vfc_probe #(
    parameter int CHUNK_EDGE = 16,
    parameter int AW         = 12
) (
    input  vfc_pkg::coord_t     x,
    input  vfc_pkg::coord_t     y,
    input  vfc_pkg::coord_t     z,
    input  vfc_pkg::probe_sel_t sel,
    output logic                in_chunk,
    output logic [AW-1:0]       addr
);

    localparam vfc_pkg::coord_ext_t EDGE_EXT = vfc_pkg::coord_ext_t'(CHUNK_EDGE);
    localparam logic [31:0] STRIDE_X = 32'(CHUNK_EDGE * CHUNK_EDGE);
    localparam logic [31:0] STRIDE_Y = 32'(CHUNK_EDGE);

    vfc_pkg::coord_ext_t px;
    vfc_pkg::coord_ext_t py;
    vfc_pkg::coord_ext_t pz;
    logic [31:0]         lin;

    always_comb
    begin
        px = vfc_pkg::coord_ext_t'(x);
        py = vfc_pkg::coord_ext_t'(y);
        pz = vfc_pkg::coord_ext_t'(z);
        // minus one at zero wraps to all ones, which lies outside the chunk
        unique case (sel)
            vfc_pkg::PROBE_SELF: ;
            vfc_pkg::PROBE_Y_DN: py = py - 7'd1;
            vfc_pkg::PROBE_Y_UP: py = py + 7'd1;
            vfc_pkg::PROBE_Z_DN: pz = pz - 7'd1;
            vfc_pkg::PROBE_Z_UP: pz = pz + 7'd1;
            vfc_pkg::PROBE_X_UP: px = px + 7'd1;
            vfc_pkg::PROBE_X_DN: px = px - 7'd1;
            default: ;
        endcase
    end

    assign in_chunk = (px < EDGE_EXT) && (py < EDGE_EXT) && (pz < EDGE_EXT);
    assign lin      = 32'(px) * STRIDE_X + 32'(py) * STRIDE_Y + 32'(pz);
    assign addr     = in_chunk ? lin[AW-1:0] : '0;

endmodule

FILE: hdl/voxel_face_culling_core.sv
// ---------------------------------------------------------------------------
// Voxel face culling core
// Holds one solid/air bit per voxel of a cubic chunk in a single-port RAM.
// Write beats set a voxel; query beats return the visible-face mask.
// ---------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   tuser: cmd (0 write, 1 query); tdata: x, y, z, block_id
//  m_axis    out  tdata: x, y, z, is_solid, face_mask, face_count
//
//  Sequence: a write beat is accepted, then written to the RAM. A query is
//  accepted, then makes 7 reads of the one RAM port (voxel then six
//  neighbours), collects the last read data and loads the result.
//  Reset: a clearing pass writes air to all CHUNK_EDGE**3 entries, one per
//  cycle (4096 entries at the default edge); s_axis_tready stays low until
//  it ends.
//  Stalls: the result sits in an output register, so the next beat is
//  taken while it waits; a query only stalls at its end if that register
//  is still full.
//
module voxel_face_culling_core #(
    parameter int CHUNK_EDGE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave side
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] pos_x, [7:4] pos_y, [11:8] pos_z, [27:12] block_id, [31:28] zero
    input  logic [vfc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic                          s_axis_tuser,
    // master side
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] out_x, [7:4] out_y, [11:8] out_z, [12] is_solid,
    // [18:13] face_mask, [21:19] face_count, [23:22] zero
    output logic [vfc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int DEPTH = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int AW    = $clog2(DEPTH);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;  // post-reset clearing pass
    localparam logic [2:0] S_IDLE  = 3'd1;  // ready for a beat
    localparam logic [2:0] S_WRITE = 3'd2;  // write one voxel
    localparam logic [2:0] S_READ  = 3'd3;  // issue voxel and neighbour reads
    localparam logic [2:0] S_DRAIN = 3'd4;  // collect last read
    localparam logic [2:0] S_DONE  = 3'd5;  // load result register

    logic [2:0]                 state_reg, state_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    vfc_pkg::coord_t            x_reg, x_next;
    vfc_pkg::coord_t            y_reg, y_next;
    vfc_pkg::coord_t            z_reg, z_next;
    logic                       solid_wr_reg, solid_wr_next;
    vfc_pkg::probe_sel_t        step_reg, step_next;
    // read pipeline: what the RAM data of this cycle belongs to
    logic                       rd_pend_reg, rd_pend_next;
    vfc_pkg::probe_sel_t        rd_sel_reg, rd_sel_next;
    logic                       rd_in_reg, rd_in_next;
    logic                       self_reg, self_next;
    vfc_pkg::face_mask_t        nb_reg, nb_next;  // neighbour solid bits
    logic                       out_valid_reg, out_valid_next;
    logic [vfc_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                       in_beat;
    vfc_pkg::probe_sel_t        probe_sel;
    logic                       probe_in;
    logic [AW-1:0]              probe_addr;
    logic                       mem_we;
    logic [AW-1:0]              mem_addr;
    logic                       mem_wdata;
    logic                       mem_rdata;
    logic                       hit;
    logic                       out_free;
    vfc_pkg::face_mask_t        mask;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // writes probe the voxel itself; reads walk the probe order
    assign probe_sel = (state_reg == S_READ) ? step_reg : vfc_pkg::PROBE_SELF;

    vfc_probe #(
        .CHUNK_EDGE (CHUNK_EDGE),
        .AW         (AW)
    ) u_probe (
        .x        (x_reg),
        .y        (y_reg),
        .z        (z_reg),
        .sel      (probe_sel),
        .in_chunk (probe_in),
        .addr     (probe_addr)
    );

    // one port: clear and write never overlap a read sequence
    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_WRITE) && probe_in);
    assign mem_addr  = (state_reg == S_CLEAR) ? clr_cnt_reg : probe_addr;
    assign mem_wdata = (state_reg == S_CLEAR) ? 1'b0 : solid_wr_reg;

    vfc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_occ_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // out-of-chunk probes read as air whatever the RAM returns
    assign hit  = rd_in_reg && mem_rdata;
    assign mask = self_reg ? ~nb_reg : '0;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        solid_wr_next  = solid_wr_reg;
        step_next      = step_reg;
        rd_pend_next   = (state_reg == S_READ);
        rd_sel_next    = step_reg;
        rd_in_next     = probe_in;
        self_next      = self_reg;
        nb_next        = nb_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        if (rd_pend_reg)
        begin
            if (rd_sel_reg == vfc_pkg::PROBE_SELF)
            begin
                self_next = hit;
            end
            else
            begin
                nb_next[3'(rd_sel_reg - vfc_pkg::PROBE_Y_DN)] = hit;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    x_next        = s_axis_tdata[3:0];
                    y_next        = s_axis_tdata[7:4];
                    z_next        = s_axis_tdata[11:8];
                    solid_wr_next = |s_axis_tdata[27:12];
                    step_next     = vfc_pkg::PROBE_SELF;
                    state_next    = (s_axis_tuser == vfc_pkg::CMD_QUERY) ? S_READ : S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_READ:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == vfc_pkg::PROBE_X_DN)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, vfc_pkg::face_popcount(mask), mask,
                                      self_reg, z_reg, y_reg, x_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        solid_wr_reg <= solid_wr_next;
        step_reg     <= step_next;
        rd_sel_reg   <= rd_sel_next;
        rd_in_reg    <= rd_in_next;
        self_reg     <= self_next;
        nb_reg       <= nb_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
`include "voxel_face_culling_core_macros.svh"

    `VFC_ASSERT_NOW(a_air_no_faces, m_axis_tvalid && !m_axis_tdata[12], m_axis_tdata[18:13] == '0, "air voxel reported visible faces")
    `VFC_ASSERT_NOW(a_count_match, m_axis_tvalid, $countones(m_axis_tdata[18:13]) == 32'(m_axis_tdata[21:19]), "face count disagrees with mask")
    `VFC_ASSERT_NOW(a_we_scope, mem_we, (state_reg == S_CLEAR) || (state_reg == S_WRITE), "RAM write outside clear or write phase")
    `VFC_ASSERT_NEXT(a_write_path, in_beat && (s_axis_tuser == vfc_pkg::CMD_WRITE), state_reg == S_WRITE, "write beat did not enter write phase")

endmodule

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// Voxel face culling core testbench
// Drives write and query beats into the core and checks every query result
// against an in-bench mirror of the chunk occupancy or a result typed in by
// hand, with random idling on both sides of the stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int EDGE         = 16;
    localparam int VOXELS       = EDGE * EDGE * EDGE;
    localparam int RANDOM_BEATS = 1725;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        vfc_pkg::coord_t      x;
        vfc_pkg::coord_t      y;
        vfc_pkg::coord_t      z;
        logic                 solid;
        vfc_pkg::face_mask_t  mask;
        vfc_pkg::face_count_t count;
    } face_result_t;

    // one stimulus row; known marks a result typed in by hand
    typedef struct {
        logic            cmd;
        vfc_pkg::coord_t x;
        vfc_pkg::coord_t y;
        vfc_pkg::coord_t z;
        logic [15:0]     id;
        bit              known;
        face_result_t    result;
    } beat_plan_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [vfc_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [vfc_pkg::M_TDATA_W-1:0] m_axis_tdata;

    bit           solid_map [0:VOXELS-1];   // mirror of the occupancy RAM
    face_result_t face_q [$];               // query results still due
    beat_plan_t   directed_beats [$];
    bit           calm_phase = 1'b0;        // no new idling begun on either side
    int           bad_beats = 0;

    voxel_face_culling_core #(
        .CHUNK_EDGE (EDGE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Occupancy mirror and face prediction
    // -----------------------------------------------------------------------

    // anything outside the chunk reads as air
    function automatic bit voxel_solid(input int x, input int y, input int z);
        if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE)
            return 1'b0;
        return solid_map[(x * EDGE + y) * EDGE + z];
    endfunction

    function automatic face_result_t predict_faces(input vfc_pkg::coord_t x,
                                                   input vfc_pkg::coord_t y,
                                                   input vfc_pkg::coord_t z);
        face_result_t r;
        int xi;
        int yi;
        int zi;
        xi = int'(x);
        yi = int'(y);
        zi = int'(z);
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.solid = voxel_solid(xi, yi, zi);
        r.mask  = '0;
        if (r.solid)
        begin
            // mask bit order: y-1, y+1, z-1, z+1, x+1, x-1
            r.mask[0] = !voxel_solid(xi, yi - 1, zi);
            r.mask[1] = !voxel_solid(xi, yi + 1, zi);
            r.mask[2] = !voxel_solid(xi, yi, zi - 1);
            r.mask[3] = !voxel_solid(xi, yi, zi + 1);
            r.mask[4] = !voxel_solid(xi + 1, yi, zi);
            r.mask[5] = !voxel_solid(xi - 1, yi, zi);
        end
        r.count = vfc_pkg::face_count_t'($countones(r.mask));
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Directed rows
    // -----------------------------------------------------------------------

    task automatic plan_write(input int x, input int y, input int z, input logic [15:0] id);
        beat_plan_t b;
        b.cmd   = vfc_pkg::CMD_WRITE;
        b.x     = vfc_pkg::coord_t'(x);
        b.y     = vfc_pkg::coord_t'(y);
        b.z     = vfc_pkg::coord_t'(z);
        b.id    = id;
        b.known = 1'b0;
        directed_beats = {directed_beats, b};
    endtask

    task automatic plan_query(input int x, input int y, input int z, input logic [15:0] id);
        beat_plan_t b;
        b.cmd   = vfc_pkg::CMD_QUERY;
        b.x     = vfc_pkg::coord_t'(x);
        b.y     = vfc_pkg::coord_t'(y);
        b.z     = vfc_pkg::coord_t'(z);
        b.id    = id;
        b.known = 1'b0;
        directed_beats = {directed_beats, b};
    endtask

    task automatic plan_query_known(input int x, input int y, input int z, input logic solid,
                                    input vfc_pkg::face_mask_t mask,
                                    input vfc_pkg::face_count_t count);
        beat_plan_t b;
        b.cmd          = vfc_pkg::CMD_QUERY;
        b.x            = vfc_pkg::coord_t'(x);
        b.y            = vfc_pkg::coord_t'(y);
        b.z            = vfc_pkg::coord_t'(z);
        b.id           = 16'h0000;
        b.known        = 1'b1;
        b.result.x     = b.x;
        b.result.y     = b.y;
        b.result.z     = b.z;
        b.result.solid = solid;
        b.result.mask  = mask;
        b.result.count = count;
        directed_beats = {directed_beats, b};
    endtask

    // -----------------------------------------------------------------------
    // Idling: mostly short gaps, now and then a long one
    // -----------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // tvalid is only lowered when a gap really follows, so a back-to-back
    // beat never sees two assignments to it in one step.
    task automatic send_beat(input beat_plan_t b);
        int gap;
        gap = 0;
        if (!calm_phase && $urandom_range(0, 99) < 40)
            gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {4'h0, 28'($urandom)};
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b.cmd;
        s_axis_tdata  <= {4'h0, b.id, b.z, b.y, b.x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (b.cmd == vfc_pkg::CMD_WRITE)
            solid_map[(int'(b.x) * EDGE + int'(b.y)) * EDGE + int'(b.z)] = (b.id != 16'h0000);
        else if (b.known)
            face_q = {face_q, b.result};
        else
            face_q = {face_q, predict_faces(b.x, b.y, b.z)};
        @(negedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stalls on tready, checking at the rising edge
    // -----------------------------------------------------------------------
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else if (!calm_phase && $urandom_range(0, 99) < 30)
            begin
                m_axis_tready <= 1'b0;
                stall = idle_len() - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        face_result_t got;
        face_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x     = m_axis_tdata[3:0];
            got.y     = m_axis_tdata[7:4];
            got.z     = m_axis_tdata[11:8];
            got.solid = m_axis_tdata[12];
            got.mask  = m_axis_tdata[18:13];
            got.count = m_axis_tdata[21:19];
            if (face_q.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= REPORT_LIMIT)
                    $display("unexpected result beat: tdata=%h", m_axis_tdata);
            end
            else
            begin
                want = face_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.solid !== want.solid || got.mask !== want.mask ||
                    got.count !== want.count)
                begin
                    bad_beats++;
                    if (bad_beats <= REPORT_LIMIT)
                        $display("mismatch: exp xyz=(%0d,%0d,%0d) solid=%0b mask=%b count=%0d",
                                 want.x, want.y, want.z, want.solid, want.mask, want.count,
                                 " | got xyz=(%0d,%0d,%0d) solid=%0b mask=%b count=%0d",
                                 got.x, got.y, got.z, got.solid, got.mask, got.count);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        beat_plan_t b;
        int         ox;
        int         oy;
        int         oz;
        int         pick;

        // fresh chunk is all air, the far corner too
        plan_query_known(0, 0, 0, 1'b0, 6'h00, 3'd0);
        plan_query(15, 15, 15, 16'hFFFF);
        // lone voxels on opposite corners show every face
        plan_write(0, 0, 0, 16'hFFFF);
        plan_query_known(0, 0, 0, 1'b1, 6'h3F, 3'd6);
        plan_write(15, 15, 15, 16'h0001);
        plan_query_known(15, 15, 15, 1'b1, 6'h3F, 3'd6);
        // grow neighbours around the origin, then erase one
        plan_write(1, 0, 0, 16'h8000);
        plan_write(0, 1, 0, 16'h1234);
        plan_write(0, 0, 1, 16'hABCD);
        plan_query(0, 0, 0, 16'h0000);
        plan_query(1, 0, 0, 16'h7FFF);
        plan_write(1, 0, 0, 16'h0000);
        plan_query(0, 0, 0, 16'h0000);
        plan_query(1, 0, 0, 16'h0000);
        // fully enclosed voxel hides all faces
        plan_write(7, 7, 7, 16'h5555);
        plan_write(6, 7, 7, 16'hAAAA);
        plan_write(8, 7, 7, 16'h00FF);
        plan_write(7, 6, 7, 16'hFF00);
        plan_write(7, 8, 7, 16'h0F0F);
        plan_write(7, 7, 6, 16'hF0F0);
        plan_write(7, 7, 8, 16'h3333);
        plan_query_known(7, 7, 7, 1'b1, 6'h00, 3'd0);
        plan_query(8, 7, 7, 16'hCCCC);
        plan_write(15, 15, 14, 16'h00FF);
        plan_query(15, 15, 15, 16'h0000);

        // reset once, released on a falling edge; the core then runs its
        // clearing pass with tready low, which the handshake wait covers
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_beats[i])
            send_beat(directed_beats[i]);

        // Random part: most traffic lands in a small box so neighbours are
        // often solid; the box moves now and then, sometimes into a corner.
        ox = 0;
        oy = 0;
        oz = 0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 128 == 0)
            begin
                calm_phase = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0)
                begin
                    ox = $urandom_range(0, 1) ? 13 : 0;
                    oy = $urandom_range(0, 1) ? 13 : 0;
                    oz = $urandom_range(0, 1) ? 13 : 0;
                end
                else
                begin
                    ox = $urandom_range(0, 13);
                    oy = $urandom_range(0, 13);
                    oz = $urandom_range(0, 13);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                b.x = vfc_pkg::coord_t'(ox + $urandom_range(0, 2));
                b.y = vfc_pkg::coord_t'(oy + $urandom_range(0, 2));
                b.z = vfc_pkg::coord_t'(oz + $urandom_range(0, 2));
            end
            else if (pick < 80)
            begin
                // chunk faces and edges
                b.x = $urandom_range(0, 1) ? 4'd15 : 4'd0;
                b.y = $urandom_range(0, 2) == 0 ? vfc_pkg::coord_t'($urandom) :
                      ($urandom_range(0, 1) ? 4'd15 : 4'd0);
                b.z = vfc_pkg::coord_t'($urandom);
            end
            else
            begin
                b.x = vfc_pkg::coord_t'($urandom);
                b.y = vfc_pkg::coord_t'($urandom);
                b.z = vfc_pkg::coord_t'($urandom);
            end
            b.cmd = ($urandom_range(0, 99) < 55) ? vfc_pkg::CMD_WRITE : vfc_pkg::CMD_QUERY;
            pick  = $urandom_range(0, 99);
            if (pick < 25)
                b.id = 16'h0000;
            else if (pick < 30)
                b.id = 16'hFFFF;
            else
                b.id = 16'($urandom_range(1, 65535));
            b.known = 1'b0;
            send_beat(b);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give the core time for anything left in flight
        while (face_q.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        if (bad_beats == 0 && face_q.size() == 0)
            $display("voxel_face_culling_core verification clean");
        else
            $display("voxel_face_culling_core verification failed");
        $finish;
    end

    // hang guard, well beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("voxel_face_culling_core verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/vfc_pkg.sv
hdl/vfc_ram.sv
hdl/vfc_probe.sv
hdl/voxel_face_culling_core.sv
bench/tb.sv
